>>> hdl/mac_address_translation_table_assert.svh
// Assertion macros used by the checker file.
`ifndef MAC_ADDRESS_TRANSLATION_TABLE_ASSERT_SVH
`define MAC_ADDRESS_TRANSLATION_TABLE_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define MAT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define MAT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/mat_pkg.sv
`timescale 1ns / 1ps
package mat_pkg;

    localparam int ADDR_W = 48;
    localparam int BKT_W  = 7;
    // Sum of six bytes is at most 1530.
    localparam int SUM_W  = 11;
    // Holds the reduction step count 0..2.
    localparam int STEP_W = 2;

    // Request kinds
    localparam logic [1:0] KIND_INSERT = 2'd0;
    localparam logic [1:0] KIND_REV    = 2'd1;
    localparam logic [1:0] KIND_FWD    = 2'd2;

    // Result status codes
    localparam logic [1:0] ST_INSERTED = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_FOUND    = 2'd2;
    localparam logic [1:0] ST_MISSING  = 2'd3;

    typedef struct packed {
        logic [1:0]        kind;
        logic [ADDR_W-1:0] base_addr;
        logic [ADDR_W-1:0] random_addr;
    } t_in;

    typedef struct packed {
        logic [1:0]        status;
        logic [ADDR_W-1:0] addr_out;
    } t_out;

    // Classified request handed from front to back
    typedef struct packed {
        logic [1:0]        kind;
        logic [ADDR_W-1:0] base_addr;
        logic [ADDR_W-1:0] random_addr;
        logic [BKT_W-1:0]  bucket;
    } t_cmd;

    // One table entry as stored in RAM
    typedef struct packed {
        logic [ADDR_W-1:0] base_addr;
        logic [ADDR_W-1:0] random_addr;
        logic [BKT_W-1:0]  bucket;
    } t_entry;

endpackage

>>> hdl/mac_address_translation_table.sv
`timescale 1ns / 1ps
// Table of base / randomized MAC address pairs with insert and two lookups.
// Request channel: drive i_item and raise push; a transfer happens on a
//   clock edge with push high and full low. kind 0 inserts, 1 looks up the
//   base address by randomized address, 2 looks up the randomized address by
//   base address (lowest bucket wins, newest on ties).
// Result channel: while empty is low, o_result holds the oldest result; it
//   is transferred on an edge with pop high. One result per request, in order.
// Processing: for an insert the front end reduces the byte sum modulo
//   NUM_BUCKETS by reciprocal multiply, quotient first, then remainder; a
//   lookup scans the stored entries newest first, the back end reading the
//   entry RAM one entry per cycle. A reverse lookup stops at the first
//   (newest) match; kind 3 reads no entry.
// Throughput: one request at a time in the back end; a lookup passes the front
//   stage without reduction, an insert holds full high through its reduction, and
//   a two-deep queue between front and back keeps the front accepting.
// Reset: synchronous, clears the entry count and all queues; RAM contents are
//   left as they are and never read before being written.
// Stall: if pop stays low the result is held, the back end waits, and full
//   rises once the queue and front stage are occupied.
module mac_address_translation_table
    import mat_pkg::*;
#(
    parameter int CAPACITY    = 64,
    parameter int NUM_BUCKETS = 100
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic push,
    output logic full,
    input  t_in  i_item,
    output logic empty,
    input  logic pop,
    output t_out o_result
);

    logic q_push;
    logic q_full;
    logic q_pop;
    logic q_empty;
    t_cmd f_cmd;
    t_cmd q_cmd;

    mat_front #(
        .NUM_BUCKETS (NUM_BUCKETS)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_item   (i_item),
        .o_full   (full),
        .o_q_push (q_push),
        .o_q_cmd  (f_cmd),
        .i_q_full (q_full)
    );

    mat_cmd_fifo u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (f_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_cmd   (q_cmd),
        .o_empty (q_empty)
    );

    mat_back #(
        .CAPACITY (CAPACITY)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_q_cmd   (q_cmd),
        .o_q_pop   (q_pop),
        .o_empty   (empty),
        .i_pop     (pop),
        .o_result  (o_result)
    );

endmodule

>>> hdl/mat_ram.sv
`timescale 1ns / 1ps
module mat_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // One write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> hdl/mat_cmd_fifo.sv
`timescale 1ns / 1ps
module mat_cmd_fifo
    import mat_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    input  logic i_pop,
    output t_cmd o_cmd,
    output logic o_empty
);

    t_cmd       r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_cnt;
    logic       wr;
    logic       rd;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign wr      = i_push && !o_full;
    assign rd      = i_pop && !o_empty;
    assign o_cmd   = r_mem[r_rd_ptr];

    // Pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_cnt    <= 2'd0;
        end else begin
            if (wr) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (rd) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            case ({wr, rd})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

>>> hdl/mat_front.sv
`timescale 1ns / 1ps
module mat_front
    import mat_pkg::*;
#(
    parameter int NUM_BUCKETS = 100
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_in  i_item,
    output logic o_full,
    output logic o_q_push,
    output t_cmd o_q_cmd,
    input  logic i_q_full
);

    // Reciprocal of NUM_BUCKETS scaled by 2^RCP_SHIFT, rounded up; the
    // quotient estimate is exact for every byte sum below 2^SUM_W
    localparam int RCP_SHIFT = 22;
    localparam int RCP_W     = RCP_SHIFT + 1;
    localparam int PROD_W    = SUM_W + RCP_W;
    localparam logic [RCP_W-1:0] RCP =
        RCP_W'(((1 << RCP_SHIFT) + NUM_BUCKETS - 1) / NUM_BUCKETS);
    localparam logic [SUM_W-1:0] NB_SUM = SUM_W'(NUM_BUCKETS);
    // Reduction steps: quotient first, then remainder
    localparam logic [STEP_W-1:0] STEP_QUO = STEP_W'(2);
    localparam logic [STEP_W-1:0] STEP_REM = STEP_W'(1);

    logic              r_valid;
    logic [1:0]        r_kind;
    logic [ADDR_W-1:0] r_base;
    logic [ADDR_W-1:0] r_random;
    logic [SUM_W-1:0]  r_rem;
    logic [SUM_W-1:0]  r_quo;
    logic [STEP_W-1:0] r_step;

    logic              done;
    logic              accept;
    logic [SUM_W-1:0]  byte_sum;
    logic [PROD_W-1:0] quo_prod;
    logic [SUM_W-1:0]  quo_est;
    logic [SUM_W-1:0]  quo_mul;

    // Byte sum of the randomized address
    always_comb begin
        byte_sum = '0;
        for (int k = 0; k < 6; k++) begin
            byte_sum = byte_sum + SUM_W'(i_item.random_addr[8*k +: 8]);
        end
    end

    assign done     = r_valid && (r_step == '0);
    assign o_full   = r_valid && !(done && !i_q_full);
    assign accept   = i_push && !o_full;
    assign o_q_push = done && !i_q_full;

    // Modulo by reciprocal multiply: quotient estimate, then remainder
    assign quo_prod = PROD_W'(r_rem) * PROD_W'(RCP);
    assign quo_est  = SUM_W'(quo_prod >> RCP_SHIFT);
    assign quo_mul  = r_quo * NB_SUM;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_step  <= '0;
        end else if (accept) begin
            r_valid <= 1'b1;
            r_step  <= (i_item.kind == KIND_INSERT) ? STEP_QUO : '0;
        end else begin
            if (o_q_push) begin
                r_valid <= 1'b0;
            end
            if (r_valid && (r_step != '0)) begin
                r_step <= r_step - STEP_W'(1);
            end
        end
    end

    // Request payload and running remainder
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_kind   <= i_item.kind;
            r_base   <= i_item.base_addr;
            r_random <= i_item.random_addr;
            r_rem    <= byte_sum;
        end else if (r_valid && (r_step == STEP_QUO)) begin
            r_quo <= quo_est;
        end else if (r_valid && (r_step == STEP_REM)) begin
            r_rem <= r_rem - quo_mul;
        end
    end

    assign o_q_cmd = '{kind: r_kind, base_addr: r_base, random_addr: r_random,
                       bucket: r_rem[BKT_W-1:0]};

endmodule

>>> hdl/mat_back.sv
`timescale 1ns / 1ps
module mat_back
    import mat_pkg::*;
#(
    parameter int CAPACITY = 64
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_q_empty,
    input  t_cmd i_q_cmd,
    output logic o_q_pop,
    output logic o_empty,
    input  logic i_pop,
    output t_out o_result
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_DONE = 3'b100
    } t_state;

    t_state            r_state, n_state;
    logic [CNT_W-1:0]  r_count, n_count;
    t_cmd              r_cmd, n_cmd;
    logic [IDX_W-1:0]  r_idx, n_idx;
    logic [1:0]        r_status, n_status;
    logic [ADDR_W-1:0] r_addr, n_addr;
    logic [BKT_W-1:0]  r_bkt, n_bkt;
    logic              r_out_valid, n_out_valid;
    t_out              r_out, n_out;

    logic              wr_en;
    logic              rd_en;
    logic [IDX_W-1:0]  rd_addr;
    t_entry            wr_entry;
    t_entry            rd_entry;
    logic [IDX_W-1:0]  last_idx;

    assign last_idx = IDX_W'(r_count - CNT_W'(1));
    assign wr_entry = '{base_addr: i_q_cmd.base_addr, random_addr: i_q_cmd.random_addr,
                        bucket: i_q_cmd.bucket};

    mat_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (CAPACITY)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (IDX_W'(r_count)),
        .i_wr_data (wr_entry),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_entry)
    );

    // Sequencer: insert writes one entry unless the table is full, lookups scan newest to oldest
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_cmd       = r_cmd;
        n_idx       = r_idx;
        n_status    = r_status;
        n_addr      = r_addr;
        n_bkt       = r_bkt;
        n_out_valid = r_out_valid && !i_pop;
        n_out       = r_out;
        wr_en       = 1'b0;
        rd_en       = 1'b0;
        rd_addr     = r_idx - IDX_W'(1);
        o_q_pop     = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (!i_q_empty) begin
                    o_q_pop  = 1'b1;
                    n_cmd    = i_q_cmd;
                    n_addr   = '0;
                    n_status = ST_MISSING;
                    n_state  = S_DONE;
                    if (i_q_cmd.kind == KIND_INSERT) begin
                        if (r_count == CNT_W'(CAPACITY)) begin
                            n_status = ST_FULL;
                        end else begin
                            wr_en    = 1'b1;
                            n_count  = r_count + CNT_W'(1);
                            n_status = ST_INSERTED;
                        end
                    end else if ((i_q_cmd.kind == KIND_REV || i_q_cmd.kind == KIND_FWD)
                                 && (r_count != '0)) begin
                        rd_en   = 1'b1;
                        rd_addr = last_idx;
                        n_idx   = last_idx;
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (r_cmd.kind == KIND_REV && rd_entry.random_addr == r_cmd.random_addr) begin
                    // newest match wins, stop early
                    n_status = ST_FOUND;
                    n_addr   = rd_entry.base_addr;
                    n_state  = S_DONE;
                end else begin
                    if (r_cmd.kind == KIND_FWD && rd_entry.base_addr == r_cmd.base_addr
                        && (r_status != ST_FOUND || rd_entry.bucket < r_bkt)) begin
                        n_status = ST_FOUND;
                        n_addr   = rd_entry.random_addr;
                        n_bkt    = rd_entry.bucket;
                    end
                    if (r_idx == '0) begin
                        n_state = S_DONE;
                    end else begin
                        rd_en = 1'b1;
                        n_idx = r_idx - IDX_W'(1);
                    end
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_pop) begin
                    n_out_valid = 1'b1;
                    n_out       = '{status: r_status, addr_out: r_addr};
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_cmd    <= n_cmd;
        r_idx    <= n_idx;
        r_status <= n_status;
        r_addr   <= n_addr;
        r_bkt    <= n_bkt;
        r_out    <= n_out;
    end

    assign o_empty  = !r_out_valid;
    assign o_result = r_out;

endmodule

>>> hdl/mat_checker.sv
`timescale 1ns / 1ps
`include "mac_address_translation_table_assert.svh"
module mat_checker
    import mat_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic push,
    input logic full,
    input t_in  i_item,
    input logic empty,
    input logic pop,
    input t_out o_result
);

    // Both channels come out of reset idle
    `MAT_ASSERT_NOW(a_reset_idle, $past(!i_rst_n), empty && !full, "not idle after reset")

    // A waiting result holds until it is transferred
    `MAT_ASSERT_NEXT(a_result_hold, !empty && !pop, !empty && $stable(o_result), "result changed")

    // Only a found result carries an address
    `MAT_ASSERT_NOW(a_addr_zero, !empty && o_result.status != ST_FOUND,
                    o_result.addr_out == '0, "address without hit")

    // An insert keeps the request side full while its bucket is computed
    `MAT_ASSERT_NEXT(a_insert_busy, push && !full && i_item.kind == KIND_INSERT, full,
                     "insert released the front too early")

endmodule

bind mac_address_translation_table mat_checker u_chk (.*);

>>> tb/mac_address_translation_table_test.sv
`timescale 1ns / 1ps
module mac_address_translation_table_test;
    import mat_pkg::*;

    localparam int TABLE_DEPTH  = 64;
    localparam int BUCKET_COUNT = 100;
    // Kind code with no operation behind it
    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam int SHOWN_MISMATCHES = 10;

    logic i_clk;
    logic i_rst_n = 1'b0;
    logic push = 1'b0;
    logic pop = 1'b0;
    logic full;
    logic empty;
    t_in  i_item = '0;
    t_out o_result;

    // Idle odds in percent, changed per phase
    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    // Mirror of the pair table
    logic [ADDR_W-1:0] tbl_base   [TABLE_DEPTH];
    logic [ADDR_W-1:0] tbl_random [TABLE_DEPTH];
    logic [BKT_W-1:0]  tbl_bucket [TABLE_DEPTH];
    int tbl_count = 0;

    t_out pending_answers[$];
    int   mismatch_count = 0;

    mac_address_translation_table #(
        .CAPACITY    (TABLE_DEPTH),
        .NUM_BUCKETS (BUCKET_COUNT)
    ) dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .push     (push),
        .full     (full),
        .i_item   (i_item),
        .empty    (empty),
        .pop      (pop),
        .o_result (o_result)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Run limit, far beyond the slowest legal run
    initial begin
        #20_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic logic [ADDR_W-1:0] draw_addr();
        return {16'($urandom_range(16'hFFFF)), 32'($urandom)};
    endfunction

    // Byte sum of the randomized address, folded into a bucket
    function automatic logic [BKT_W-1:0] addr_bucket(logic [ADDR_W-1:0] mac);
        int sum;
        sum = 0;
        for (int k = 0; k < 6; k++) sum += mac[8*k +: 8];
        return BKT_W'(sum % BUCKET_COUNT);
    endfunction

    // Expected answer for one request; updates the mirrored table
    function automatic t_out translate_request(t_in req);
        t_out ans;
        logic hit;
        logic [BKT_W-1:0] best_bucket;
        ans.status   = ST_MISSING;
        ans.addr_out = '0;
        hit          = 1'b0;
        best_bucket  = '0;
        case (req.kind)
            KIND_INSERT: begin
                if (tbl_count >= TABLE_DEPTH) begin
                    ans.status = ST_FULL;
                end else begin
                    tbl_base[tbl_count]   = req.base_addr;
                    tbl_random[tbl_count] = req.random_addr;
                    tbl_bucket[tbl_count] = addr_bucket(req.random_addr);
                    tbl_count++;
                    ans.status = ST_INSERTED;
                end
            end
            KIND_REV: begin
                // newest match wins
                for (int e = tbl_count - 1; e >= 0 && !hit; e--) begin
                    if (tbl_random[e] == req.random_addr) begin
                        hit          = 1'b1;
                        ans.addr_out = tbl_base[e];
                    end
                end
                if (hit) ans.status = ST_FOUND;
            end
            KIND_FWD: begin
                // lowest bucket wins, newest on a tie
                for (int e = tbl_count - 1; e >= 0; e--) begin
                    if (tbl_base[e] == req.base_addr && (!hit || tbl_bucket[e] < best_bucket)) begin
                        hit          = 1'b1;
                        best_bucket  = tbl_bucket[e];
                        ans.addr_out = tbl_random[e];
                    end
                end
                if (hit) ans.status = ST_FOUND;
            end
            default: ;
        endcase
        return ans;
    endfunction

    function automatic void note_mismatch(string what, t_out want, t_out got);
        mismatch_count++;
        if (mismatch_count <= SHOWN_MISMATCHES)
            $display("%0t %s: expected status %0d addr %012h, got status %0d addr %012h",
                     $realtime, what, want.status, want.addr_out, got.status, got.addr_out);
    endfunction

    // Offer one request; returns at the edge of its transfer
    task automatic send_item(input t_in req);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct) gap++;
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push   <= 1'b1;
        i_item <= req;
        do @(posedge i_clk); while (full);
        pending_answers.push_back(translate_request(req));
    endtask

    // Result side: check each transfer, then pick pop for the next cycle
    always @(posedge i_clk) begin
        t_out want;
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                if (pending_answers.size() == 0) begin
                    note_mismatch("unexpected result", '0, o_result);
                end else begin
                    want = pending_answers.pop_front();
                    if (o_result.status !== want.status)
                        note_mismatch("status mismatch", want, o_result);
                    if (o_result.addr_out !== want.addr_out)
                        note_mismatch("addr_out mismatch", want, o_result);
                end
            end
            pop <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic send_req(input logic [1:0] kind, input logic [ADDR_W-1:0] base_val,
                            input logic [ADDR_W-1:0] rand_mac);
        t_in req;
        req.kind        = kind;
        req.base_addr   = base_val;
        req.random_addr = rand_mac;
        send_item(req);
    endtask

    // Extremes, every kind, duplicates and bucket ties
    task automatic test_directed_basics();
        logic [ADDR_W-1:0] shared_base;
        logic [ADDR_W-1:0] shared_rand;
        shared_base = 48'h02_11_22_33_44_55;
        shared_rand = 48'h0A_0B_0C_0D_0E_0F;
        // lookups on an empty table miss
        send_req(KIND_REV, '1, '1);
        send_req(KIND_FWD, '0, '0);
        send_req(KIND_UNUSED, '0, '0);
        // address extremes
        send_req(KIND_INSERT, '0, '1);
        send_req(KIND_INSERT, '1, '0);
        // same base into buckets 99, 5, then a tie on 5, then 99 again
        send_req(KIND_INSERT, shared_base, 48'h00_00_00_00_00_63);
        send_req(KIND_INSERT, shared_base, 48'h00_00_00_00_00_05);
        send_req(KIND_INSERT, shared_base, 48'h00_00_00_00_01_04);
        send_req(KIND_INSERT, shared_base, 48'h00_00_00_00_32_31);
        // duplicate randomized address under two bases
        send_req(KIND_INSERT, 48'hAA_AA_AA_AA_AA_AA, shared_rand);
        send_req(KIND_INSERT, 48'h55_55_55_55_55_55, shared_rand);
        send_req(KIND_REV, '0, '1);
        send_req(KIND_REV, '0, '0);
        send_req(KIND_FWD, '0, '1);
        send_req(KIND_FWD, '1, '0);
        send_req(KIND_FWD, shared_base, '0);
        send_req(KIND_REV, '1, shared_rand);
        send_req(KIND_FWD, 48'hAA_AA_AA_AA_AA_AA, '1);
        send_req(KIND_REV, '0, 48'h12_34_56_78_9A_BC);
        send_req(KIND_FWD, 48'h12_34_56_78_9A_BC, '0);
        send_req(KIND_UNUSED, '1, '1);
    endtask

    // Mostly lookups of stored pairs, with sparse inserts and some noise
    task automatic test_random_traffic(input int item_total);
        t_in req;
        int  roll;
        int  pick;
        for (int n = 0; n < item_total; n++) begin
            roll            = $urandom_range(99);
            req.base_addr   = draw_addr();
            req.random_addr = draw_addr();
            pick            = (tbl_count > 0) ? $urandom_range(tbl_count - 1) : 0;
            if (roll < 5) begin
                req.kind = KIND_INSERT;
                roll     = $urandom_range(99);
                if (tbl_count > 0 && roll < 30) req.base_addr = tbl_base[pick];
                else if (tbl_count > 0 && roll < 45) req.random_addr = tbl_random[pick];
            end else if (roll < 8) begin
                req.kind = KIND_UNUSED;
            end else begin
                req.kind = $urandom_range(1) ? KIND_REV : KIND_FWD;
                roll     = $urandom_range(99);
                if (tbl_count > 0 && roll < 75) begin
                    req.base_addr   = tbl_base[pick];
                    req.random_addr = tbl_random[pick];
                end else if (tbl_count > 0 && roll < 85) begin
                    // near miss: one bit off a stored pair
                    req.base_addr   = tbl_base[pick] ^ (48'd1 << $urandom_range(ADDR_W - 1));
                    req.random_addr = tbl_random[pick] ^ (48'd1 << $urandom_range(ADDR_W - 1));
                end
            end
            send_item(req);
        end
    endtask

    // Fill to capacity, then refused inserts and lookups on a full table
    task automatic test_table_full();
        while (tbl_count < TABLE_DEPTH)
            send_req(KIND_INSERT, draw_addr(), draw_addr());
        send_req(KIND_INSERT, '1, '1);
        send_req(KIND_INSERT, '0, '0);
        send_req(KIND_INSERT, tbl_base[0], tbl_random[0]);
        send_req(KIND_REV, '0, tbl_random[TABLE_DEPTH - 1]);
        send_req(KIND_FWD, tbl_base[TABLE_DEPTH - 1], '0);
        test_random_traffic(40);
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_idle_pct = 35;
        recv_idle_pct = 76;
        test_directed_basics();
        test_random_traffic(340);

        send_idle_pct = 76;
        recv_idle_pct = 35;
        test_random_traffic(340);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_traffic(340);
        test_table_full();
        push <= 1'b0;

        // drain, then allow for a late stray result
        while (pending_answers.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
